[sv/assert_macros.svh]
// Assertion helpers used by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SNA_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");

`define SNA_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`else

`define SNA_ASSERT_IMPL(lbl, clk, rst, a, c)

`define SNA_ASSERT_NEXT(lbl, clk, rst, a, c)

`endif

`endif

[sv/sna_pkg.sv]
package sna_pkg;

  localparam int ACT_W       = 16;
  localparam int PROD_W      = 32;
  localparam int Z_W         = 24;
  localparam int SIG_W       = 16;
  localparam int SLOPE_W     = 14;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic [Z_W-1:0] Z_MAX = 24'h7F_FFFF;
  localparam logic [Z_W-1:0] Z_MIN = 24'h80_0000;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[sv/sna_front.sv]
module sna_front #(
  parameter int SUM_WIDTH = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sna_pkg::ACT_W-1:0]       activation_in,
  input  logic [sna_pkg::ACT_W-1:0]       weight_in,
  input  logic [sna_pkg::ACT_W-1:0]       bias_in,
  input  logic                            last_term,
  input  sna_pkg::q_stat_t                q_stat,
  output logic                            push,
  output logic [SUM_WIDTH+sna_pkg::ACT_W-1:0] push_data
);
  import sna_pkg::*;

  logic                    p_valid;
  logic                    p_last;
  logic signed [PROD_W-1:0] p_prod;
  logic [ACT_W-1:0]        p_bias;
  logic [SUM_WIDTH-1:0]    product_sum;
  logic [SUM_WIDTH-1:0]    total;
  logic signed [PROD_W-1:0] prod_next;
  logic                    advance;

  // product stage holds when a last item meets a full queue
  assign in_ready  = !(p_valid && p_last && q_stat.full);
  assign advance   = p_valid && !(p_last && q_stat.full);
  assign prod_next = $signed(activation_in) * $signed(weight_in);
  assign total     = product_sum + {{(SUM_WIDTH-PROD_W){p_prod[PROD_W-1]}}, p_prod};
  assign push      = advance && p_last;
  assign push_data = {p_bias, total};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
    if (in_ready) begin
      p_last <= last_term;
      p_prod <= prod_next;
      p_bias <= bias_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product_sum <= '0;
    end else if (advance) begin
      product_sum <= p_last ? '0 : total;
    end
  end

endmodule

[sv/sna_queue.sv]
module sna_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output sna_pkg::q_stat_t q_stat
);
  import sna_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == FULL_CNT);
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/sna_back.sv]
module sna_back #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int SUM_WIDTH     = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sna_pkg::q_stat_t                    q_stat,
  input  logic [SUM_WIDTH+sna_pkg::ACT_W-1:0] head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sna_pkg::Z_W-1:0]             preact_z,
  output logic [sna_pkg::SIG_W-1:0]           activation_out,
  output logic [sna_pkg::SLOPE_W-1:0]         slope_out
);
  import sna_pkg::*;

  localparam int HALF  = TABLE_ENTRIES / 2;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int OFF_W = IDX_W + 6;
  localparam int SH_W  = SUM_WIDTH - 12;
  localparam int ZW_W  = SH_W + 1;
  localparam logic signed [Z_W:0] CLAMP_LO = (Z_W+1)'(-(HALF * 64));
  localparam logic signed [Z_W:0] CLAMP_HI = (Z_W+1)'(HALF * 64 - 1);
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  typedef logic [SIG_W-1:0] rom_t [TABLE_ENTRIES];

  function automatic logic [63:0] div_u128(input logic [127:0] num, input logic [63:0] den);
    logic [64:0]  r;
    logic [127:0] q;
    r = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      q = {q[126:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << 61);
    return p[125:62];
  endfunction

  // sigmoid samples at steps of 1/64, built from a Taylor series of exp(-1/64)
  function automatic rom_t build_rom();
    rom_t         rom;
    logic [63:0]  step;
    logic [63:0]  term;
    logic [63:0]  e;
    logic [63:0]  q;
    logic [63:0]  pos;
    logic [127:0] num;
    rom  = '{default: '0};
    step = ONE_Q62;
    term = ONE_Q62;
    e    = ONE_Q62;
    for (int n = 1; n <= 14; n++) begin
      term = div_u128({64'd0, term}, 64'(64 * n));
      if (n[0]) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    num = {64'd32767, 64'h8000_0000_0000_0000};
    for (int k = 0; k <= HALF; k++) begin
      q   = div_u128(num, ONE_Q62 + e);
      pos = (q + 64'd1) >> 1;
      if (k < HALF) begin
        rom[HALF + k] = pos[SIG_W-1:0];
      end
      if (k >= 1) begin
        rom[HALF - k] = 16'hFFFF - pos[SIG_W-1:0];
      end
      e = mul_q62(e, step);
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  logic                      en;
  logic signed [SUM_WIDTH-1:0] total;
  logic signed [ACT_W-1:0]   bias;
  logic signed [ZW_W-1:0]    z_wide;
  logic [Z_W-1:0]            z_sat;
  logic signed [Z_W:0]       zx;
  logic signed [Z_W:0]       zc;
  logic [Z_W:0]              off;
  logic [IDX_W-1:0]          idx;
  logic [2*SIG_W-1:0]        slope_prod;

  logic                      b1_valid;
  logic [Z_W-1:0]            b1_z;
  logic                      b2_valid;
  logic [Z_W-1:0]            b2_z;
  logic [SIG_W-1:0]          b2_s;

  assign en    = !out_valid || out_ready;
  assign pop   = en && !q_stat.empty;
  assign total = head[SUM_WIDTH-1:0];
  assign bias  = head[SUM_WIDTH+ACT_W-1:SUM_WIDTH];

  // floor shift, bias, saturate to 24 bits
  always_comb begin
    z_wide = {total[SUM_WIDTH-1], total[SUM_WIDTH-1:12]}
             + {{(ZW_W-ACT_W){bias[ACT_W-1]}}, bias};
    if (z_wide[ZW_W-1:Z_W-1] == {(ZW_W-Z_W+1){z_wide[ZW_W-1]}}) begin
      z_sat = z_wide[Z_W-1:0];
    end else begin
      z_sat = z_wide[ZW_W-1] ? Z_MIN : Z_MAX;
    end
  end

  // clamp to the table span and form the index
  always_comb begin
    zx = {b1_z[Z_W-1], b1_z};
    if (zx < CLAMP_LO) begin
      zc = CLAMP_LO;
    end else if (zx > CLAMP_HI) begin
      zc = CLAMP_HI;
    end else begin
      zc = zx;
    end
    off = zc - CLAMP_LO;
    idx = off[OFF_W-1:6];
  end

  assign slope_prod = b2_s * (16'hFFFF - b2_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= !q_stat.empty;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_z           <= z_sat;
      b2_z           <= b1_z;
      b2_s           <= SIG_ROM[idx];
      preact_z       <= b2_z;
      activation_out <= b2_s;
      slope_out      <= slope_prod[SIG_W+SLOPE_W-1:SIG_W];
    end
  end

endmodule

[sv/sigmoid_neuron_accumulate_core.sv]
// Sigmoid neuron row: multiply-accumulate of weight terms with a sigmoid output.
// Input channel s_*: one weight term per item, s_tlast marks the row's final term.
// Each item's Q4.12 activation and weight are multiplied and summed exactly;
// on the final term the sum is shifted, biased, saturated, and the sigmoid and
// its slope are looked up and computed, then the accumulator clears.
// Output channel m_*: one result item per row, none for the other terms.
// Throughput: one input item per cycle while s_tready is high, one result per
// cycle while m_tready is high; the product register loads with s_tready high.
// A final term's result goes through product, accumulate and enqueue,
// saturate, table read and slope multiply, in that order.
// A 4-deep queue of finished sums sits between the accumulator and the
// activation pipeline. When m_tready is low, the activation pipeline holds,
// the queue fills, and s_tready drops only when a final term finds it full;
// terms that are not final keep flowing meanwhile.
// Reset: synchronous, clears the accumulator, the queue and all valid flags.
// The sigmoid table is a constant ROM, so no fill time after reset.
module sigmoid_neuron_accumulate_core #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int SUM_WIDTH     = 48,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // activation_in[15:0], weight_in[31:16], bias_in[47:32]
  input  logic [sna_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // preact_z[23:0], activation_out[39:24], slope_out[53:40], zero[55:54]
  output logic [sna_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import sna_pkg::*;

  `include "assert_macros.svh"

  localparam int Q_W = SUM_WIDTH + ACT_W;

  q_stat_t          q_stat;
  logic             push;
  logic             pop;
  logic [Q_W-1:0]   push_data;
  logic [Q_W-1:0]   head;
  logic [Z_W-1:0]   preact_z;
  logic [SIG_W-1:0] activation_out;
  logic [SLOPE_W-1:0] slope_out;

  sna_front #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .activation_in (s_tdata[15:0]),
    .weight_in     (s_tdata[31:16]),
    .bias_in       (s_tdata[47:32]),
    .last_term     (s_tlast),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  sna_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  sna_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .preact_z       (preact_z),
    .activation_out (activation_out),
    .slope_out      (slope_out)
  );

  assign m_tdata = {2'b00, slope_out, activation_out, preact_z};

  `SNA_ASSERT_IMPL(a_no_overflow, clk, rst, push, !q_stat.full)
  `SNA_ASSERT_IMPL(a_no_underflow, clk, rst, pop, !q_stat.empty)
  `SNA_ASSERT_IMPL(a_stall_cause, clk, rst, !s_tready, q_stat.full)
  `SNA_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !m_tvalid && q_stat.empty)

endmodule

[tb/sv/sna_result_check.sv]
module sna_result_check
  import sna_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LUT_N    = 1024;
  localparam int LUT_HALF = LUT_N / 2;
  localparam int SUM_W    = 48;
  localparam logic [127:0] ONE_Q62 = 128'd1 << 62;

  typedef struct packed {
    logic [Z_W-1:0]     z;
    logic [SIG_W-1:0]   sig;
    logic [SLOPE_W-1:0] slope;
  } row_result_t;

  logic [SIG_W-1:0] sig_lut [LUT_N];
  logic [SUM_W-1:0] row_sum;
  row_result_t      row_results_q [$];

  initial fail_count = 0;
  initial pending = 0;

  // exp(-k/64) in Q62 by repeated multiply, then round(65535 / (1 + e))
  function automatic void build_sigmoid_lut();
    logic [127:0] stepv, termv, ev, q, pos;
    logic [127:0] num;
    stepv = ONE_Q62;
    termv = ONE_Q62;
    ev = ONE_Q62;
    num = (128'd32767 << 64) | (128'd1 << 63);
    for (int n = 1; n <= 14; n++) begin
      termv = termv / (64 * n);
      if (n % 2 == 1) begin
        stepv = stepv - termv;
      end else begin
        stepv = stepv + termv;
      end
    end
    for (int k = 0; k <= LUT_HALF; k++) begin
      q = num / (ONE_Q62 + ev);
      pos = (q + 128'd1) >> 1;
      if (k < LUT_HALF) sig_lut[LUT_HALF + k] = pos[15:0];
      if (k >= 1) sig_lut[LUT_HALF - k] = 16'd65535 - pos[15:0];
      ev = (ev * stepv + (128'd1 << 61)) >> 62;
    end
  endfunction

  initial build_sigmoid_lut();

  function automatic row_result_t fold_row(input logic [SUM_W-1:0] total,
                                           input logic [ACT_W-1:0] bias);
    longint      zv, zc;
    int          idx;
    logic [31:0] sq;
    row_result_t r;
    zv = ($signed({{(64-SUM_W){total[SUM_W-1]}}, total}) >>> 12)
       + $signed({{(64-ACT_W){bias[ACT_W-1]}}, bias});
    if (zv > longint'($signed(Z_MAX))) zv = longint'($signed(Z_MAX));
    if (zv < longint'($signed(Z_MIN))) zv = longint'($signed(Z_MIN));
    zc = zv;
    if (zc < -LUT_HALF * 64) zc = -LUT_HALF * 64;
    if (zc > LUT_HALF * 64 - 1) zc = LUT_HALF * 64 - 1;
    idx = int'((zc + LUT_HALF * 64) >>> 6);
    r.z = zv[Z_W-1:0];
    r.sig = sig_lut[idx];
    sq = {16'd0, r.sig} * (32'd65535 - {16'd0, r.sig});
    r.slope = sq[16 +: SLOPE_W];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    logic signed [31:0] prod;
    logic [SUM_W-1:0]   total;
    row_result_t        want;
    if (rst) begin
      row_sum = '0;
      row_results_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        prod = $signed(s_tdata[15:0]) * $signed(s_tdata[31:16]);
        total = row_sum + {{(SUM_W-32){prod[31]}}, prod};
        if (s_tlast) begin
          row_results_q.push_back(fold_row(total, s_tdata[47:32]));
          row_sum = '0;
        end else begin
          row_sum = total;
        end
      end
      if (m_tvalid && m_tready) begin
        if (row_results_q.size() == 0) begin
          report_mismatch("unexpected result item", m_tdata[31:0], 32'd0);
        end else begin
          want = row_results_q.pop_front();
          if (m_tdata[23:0] !== want.z)
            report_mismatch("preact_z", 32'(m_tdata[23:0]), 32'(want.z));
          if (m_tdata[39:24] !== want.sig)
            report_mismatch("activation_out", 32'(m_tdata[39:24]), 32'(want.sig));
          if (m_tdata[53:40] !== want.slope)
            report_mismatch("slope_out", 32'(m_tdata[53:40]), 32'(want.slope));
          if (m_tdata[55:54] !== 2'b00)
            report_mismatch("tdata padding", 32'(m_tdata[55:54]), 32'd0);
        end
      end
    end
    pending <= row_results_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import sna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TERMS = 900;
  localparam int QUIET_TERMS  = 300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int                     fail_count;
  int                     pending;
  int                     src_idle_pct = 33;
  int                     snk_idle_pct = 33;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sigmoid_neuron_accumulate_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sna_result_check u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_term(input logic [15:0] act, input logic [15:0] wt,
                           input logic [15:0] bias, input logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {bias, wt, act};
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
  endtask

  // mix of full-range, in-table-range and extreme Q4.12 values
  function automatic logic [15:0] pick_q412();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(8191)) - 16'd4096;
      2: return 16'($urandom_range(2047)) - 16'd1024;
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_rows(input int n_terms);
    int sent;
    int len;
    sent = 0;
    while (sent < n_terms) begin
      case ($urandom_range(15)) inside
        [0:3]: len = 1;
        4: len = $urandom_range(33, 48);
        default: len = $urandom_range(2, 8);
      endcase
      for (int i = 0; i < len; i++) begin
        send_term(pick_q412(), pick_q412(), pick_q412(), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    send_term(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_term(16'hFFFF, 16'h0001, 16'h0000, 1'b1);  // negative product, floor
    send_term(16'h0001, 16'h0001, 16'h0000, 1'b1);
    send_term(16'h0000, 16'h0000, 16'h8000, 1'b1);  // bottom table entry
    send_term(16'h0000, 16'h0000, 16'h7FFF, 1'b1);  // top table entry
    send_term(16'h0001, 16'hFFFF, 16'h8000, 1'b1);  // just below table range
    send_term(16'h1000, 16'h1000, 16'h7FFF, 1'b1);  // just above table range
    send_term(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_term(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_term(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    send_term(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
    send_term(16'h0800, 16'hF800, 16'h0040, 1'b1);
    // bias only counts on the last term
    send_term(16'h1000, 16'h1000, 16'h5A5A, 1'b0);
    send_term(16'hF000, 16'h0800, 16'hA5A5, 1'b0);
    send_term(16'h0400, 16'hFC00, 16'h7FFF, 1'b0);
    send_term(16'h1000, 16'h1000, 16'h1234, 1'b1);
    // z saturates high, then low
    for (int i = 0; i < 40; i++) send_term(16'h8000, 16'h8000, 16'h0000, i == 39);
    for (int i = 0; i < 40; i++) send_term(16'h8000, 16'h7FFF, 16'h8000, i == 39);

    send_random_rows(RANDOM_TERMS - QUIET_TERMS);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random_rows(QUIET_TERMS);

    src_idle_pct = 33;
    snk_idle_pct = 33;
    send_random_rows(40);

    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sna_pkg.sv
sv/sna_front.sv
sv/sna_queue.sv
sv/sna_back.sv
sv/sigmoid_neuron_accumulate_core.sv
tb/sv/sna_result_check.sv
tb/sv/tb_top.sv
